// ===== hdl/alt_pkg.sv =====
// Shared types and codes for the array list table.
package alt_pkg;

   typedef enum logic [1:0] {
      KIND_INSERT     = 2'd0,
      KIND_DELETE     = 2'd1,
      KIND_DELETE_ALL = 2'd2,
      KIND_FIND       = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      kind_type           kind;
      logic [3:0]         position;
      logic signed [31:0] value;
   } alt_req_type;

   typedef struct packed {
      status_type status;
      logic [3:0] found_position;
      logic [4:0] count;
   } alt_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic rsp_load;
   } alt_cmd_type;

   typedef struct packed {
      logic scan_done;
   } alt_stat_type;

endpackage

// ===== hdl/alt_dp.sv =====
// Datapath of the array list table: entry memory, scan pointers and result register.
module alt_dp
   import alt_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  alt_cmd_type  cmd,
   input  alt_req_type  req_payload,
   output alt_stat_type stat,
   output alt_rsp_type  rsp_payload
);

   localparam int LW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic [31:0]   mem [DEPTH];

   logic [LW-1:0] len_ff, len_in;
   kind_type      kind_ff;
   logic [AW-1:0] pos_ff;
   logic [31:0]   val_ff;
   logic          err_ff, err_in;
   status_type    err_status_ff, err_status_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] remain_ff, remain_in;
   logic [AW-1:0] raddr_ff;
   logic          rvalid_ff;
   logic [31:0]   rdata_ff;
   logic [LW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          found_ff, found_in;
   logic [AW-1:0] found_pos_ff, found_pos_in;
   status_type    res_status_ff, res_status_in;
   logic [AW-1:0] res_pos_ff, res_pos_in;
   alt_rsp_type   rsp_ff;

   logic          we;
   logic [AW-1:0] waddr;
   logic [31:0]   wdata;
   logic [LW-1:0] pos_l;

   assign pos_l = LW'(req_payload.position);

   // Range checks and scan setup for a new request.
   always_comb begin
      err_in        = 1'b0;
      err_status_in = ST_OK;
      remain_in     = '0;
      rd_ptr_in     = '0;
      case (req_payload.kind)
         KIND_INSERT: begin
            if (32'(len_ff) == DEPTH) begin
               err_in        = 1'b1;
               err_status_in = ST_FULL;
            end else if (32'(req_payload.position) > 32'(len_ff)) begin
               err_in        = 1'b1;
               err_status_in = ST_BADPOS;
            end else begin
               remain_in = len_ff - pos_l;
               rd_ptr_in = AW'(len_ff - LW'(1));
            end
         end
         KIND_DELETE: begin
            if (len_ff == '0) begin
               err_in        = 1'b1;
               err_status_in = ST_EMPTY;
            end else if (32'(req_payload.position) >= 32'(len_ff)) begin
               err_in        = 1'b1;
               err_status_in = ST_BADPOS;
            end else begin
               remain_in = len_ff - pos_l - LW'(1);
               rd_ptr_in = AW'(pos_l + LW'(1));
            end
         end
         default: begin
            if (len_ff == '0) begin
               err_in        = 1'b1;
               err_status_in = ST_EMPTY;
            end else begin
               remain_in = len_ff;
            end
         end
      endcase
      if (!cmd.load) begin
         err_in        = err_ff;
         err_status_in = err_status_ff;
         remain_in     = remain_ff;
         rd_ptr_in     = rd_ptr_ff;
         if (cmd.step) begin
            remain_in = remain_ff - LW'(1);
            if (kind_ff == KIND_INSERT) begin
               rd_ptr_in = rd_ptr_ff - AW'(1);
            end else begin
               rd_ptr_in = rd_ptr_ff + AW'(1);
            end
         end
      end
   end

   // Each returned entry is moved, compacted or compared in the cycle after its read.
   always_comb begin
      we           = 1'b0;
      waddr        = raddr_ff;
      wdata        = rdata_ff;
      wr_ptr_in    = cmd.load ? '0 : wr_ptr_ff;
      found_in     = cmd.load ? 1'b0 : found_ff;
      found_pos_in = found_pos_ff;
      if (rvalid_ff) begin
         case (kind_ff)
            KIND_INSERT: begin
               we    = 1'b1;
               waddr = raddr_ff + AW'(1);
            end
            KIND_DELETE: begin
               we    = 1'b1;
               waddr = raddr_ff - AW'(1);
            end
            KIND_DELETE_ALL: begin
               if (rdata_ff != val_ff) begin
                  we        = 1'b1;
                  waddr     = wr_ptr_ff[AW-1:0];
                  wr_ptr_in = wr_ptr_ff + LW'(1);
               end
            end
            default: begin
               if (rdata_ff == val_ff && !found_ff) begin
                  found_in     = 1'b1;
                  found_pos_in = raddr_ff;
               end
            end
         endcase
      end else if (cmd.finish && !err_ff && kind_ff == KIND_INSERT) begin
         we    = 1'b1;
         waddr = pos_ff;
         wdata = val_ff;
      end
   end

   // Commit of the new length, the result code and the found position.
   always_comb begin
      len_in        = len_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      if (cmd.finish) begin
         res_status_in = ST_OK;
         res_pos_in    = '0;
         if (err_ff) begin
            res_status_in = err_status_ff;
         end else begin
            case (kind_ff)
               KIND_INSERT: len_in = len_ff + LW'(1);
               KIND_DELETE: len_in = len_ff - LW'(1);
               KIND_DELETE_ALL: begin
                  if (wr_ptr_ff == len_ff) begin
                     res_status_in = ST_NOTFOUND;
                  end else begin
                     len_in = wr_ptr_ff;
                  end
               end
               default: begin
                  if (found_ff) begin
                     res_pos_in = found_pos_ff;
                  end else begin
                     res_status_in = ST_NOTFOUND;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         rvalid_ff <= cmd.step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_payload.kind;
         pos_ff  <= AW'(req_payload.position);
         val_ff  <= req_payload.value;
      end
      err_ff        <= err_in;
      err_status_ff <= err_status_in;
      remain_ff     <= remain_in;
      rd_ptr_ff     <= rd_ptr_in;
      raddr_ff      <= rd_ptr_ff;
      wr_ptr_ff     <= wr_ptr_in;
      found_ff      <= found_in;
      found_pos_ff  <= found_pos_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      if (cmd.rsp_load) begin
         rsp_ff.status         <= res_status_ff;
         rsp_ff.found_position <= 4'(res_pos_ff);
         rsp_ff.count          <= 5'(len_ff);
      end
   end

   assign stat.scan_done = (remain_ff == '0);
   assign rsp_payload    = rsp_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= DEPTH)
      else $error("entry count exceeds the store depth");

   a_finish_no_move: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rvalid_ff)
      else $error("final write collides with a pending entry move");

   a_read_follows_step: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> $past(cmd.step))
      else $error("read data marked valid without a read request");

endmodule

// ===== hdl/alt_ctrl.sv =====
// Controller of the array list table: sequences scan, commit and result transfer.
module alt_ctrl
   import alt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  alt_stat_type stat,
   output alt_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DRAIN  = 5'b00100,
      S_FINISH = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready    = (state_ff == S_IDLE);
   assign cmd.load     = req_valid && req_ready;
   assign cmd.step     = (state_ff == S_SCAN) && !stat.scan_done;
   assign cmd.finish   = (state_ff == S_FINISH);
   assign cmd.rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN:  state_in = S_FINISH;
         S_FINISH: state_in = S_DONE;
         S_DONE: begin
            if (cmd.rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_accept_on_result: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && cmd.rsp_load))
      else $error("request accepted while a result is being loaded");

   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DRAIN |-> $past(stat.scan_done))
      else $error("scan ended before all reads were issued");

   a_result_after_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> ($past(state_ff == S_FINISH) || $past(state_ff == S_DONE)))
      else $error("result loaded without a committed operation");

endmodule

// ===== hdl/array_list_table.sv =====
// Top level of the array list table: an ordered list of 32-bit values in a fixed store.
// A request transfer on req_ carries a kind (insert, delete, delete all equal, find),
// a position and a value; each request gives exactly one result transfer on rsp_
// with a status, the found position and the entry count after the operation.
// Requests are handled one at a time. The entry memory has one read and one write
// port, and each operation walks the affected entries through it, one read per
// cycle with the move or compare in the cycle after the read. A request passes through
// scan, drain, commit and result load. The scan reads length - position entries for
// insert, length - position - 1 for delete, length for delete all and find, and none
// when the request is rejected.
// The result sits in an output register; the next request is accepted as soon as
// the result is loaded, even if the receiver has not yet taken it. If the receiver
// stalls with an earlier result still held, the finished operation waits and
// req_ready stays low until the output register frees.
// Synchronous reset empties the list and drops any pending result; entry contents
// are not cleared, since only entries below the count are ever read.
module array_list_table
   import alt_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  alt_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output alt_rsp_type rsp_payload
);

   alt_cmd_type  cmd;
   alt_stat_type stat;

   alt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   alt_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule
